>>> rtl/core/pixel_format_to_argb32_assert.svh
// Assertion macros shared by the pixel format converter RTL.
`ifndef PIXEL_FORMAT_TO_ARGB32_ASSERT_SVH
`define PIXEL_FORMAT_TO_ARGB32_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PF2A_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PF2A_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/pf2a_pkg.sv
// Shared constants and types of the pixel format converter.
`timescale 1ns / 1ps
package pf2a_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   localparam int PIXEL_W   = 32;
   localparam int INDEX_W   = 8;
   localparam int COLOR_W   = 16;
   localparam int RGB_W     = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DW    = 32;

   typedef enum logic {
      OP_CONVERT   = 1'b0,
      OP_PAL_WRITE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_BYTES  = 3'd0,
      CSR_VISUAL_CLASS = 3'd1,
      CSR_PAL_ENTRIES  = 3'd2,
      CSR_RED_MASK     = 3'd3,
      CSR_GREEN_MASK   = 3'd4,
      CSR_BLUE_MASK    = 3'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      FMT_ERROR,
      FMT_PALETTE,
      FMT_RGB565,
      FMT_BGR565,
      FMT_RGBX555,
      FMT_RGB888,
      FMT_BGR888,
      FMT_ARGBX888,
      FMT_ABGRX888,
      FMT_RGBA888X,
      FMT_BGRA888X,
      FMT_ARGBX666
   } fmt_type;

   // Visual classes; everything up to PSEUDOCOLOR is indexed.
   localparam logic [2:0] VC_PSEUDOCOLOR = 3'd3;
   localparam logic [2:0] VC_DIRECTCOLOR = 3'd5;

   // Pixel sizes in bytes.
   localparam logic [2:0] BYTES_1 = 3'd1;
   localparam logic [2:0] BYTES_2 = 3'd2;
   localparam logic [2:0] BYTES_3 = 3'd3;
   localparam logic [2:0] BYTES_4 = 3'd4;

   // Channel masks that identify the packings.
   localparam logic [31:0] M_FF0000   = 32'h00ff0000;
   localparam logic [31:0] M_00FF00   = 32'h0000ff00;
   localparam logic [31:0] M_0000FF   = 32'h000000ff;
   localparam logic [31:0] M_FF000000 = 32'hff000000;
   localparam logic [31:0] M_R666     = 32'h0003f000;
   localparam logic [31:0] M_G666     = 32'h00000fc0;
   localparam logic [31:0] M_B666     = 32'h0000003f;
   localparam logic [31:0] M_R565     = 32'h0000f800;
   localparam logic [31:0] M_G565     = 32'h000007e0;
   localparam logic [31:0] M_B565     = 32'h0000001f;
   localparam logic [31:0] M_R555     = 32'h00007c00;
   localparam logic [31:0] M_G555     = 32'h000003e0;

endpackage

>>> rtl/core/pf2a_channels_if.sv
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps
interface pf2a_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [pf2a_pkg::PIXEL_W-1:0]  pixel_word;
   logic [pf2a_pkg::INDEX_W-1:0]  palette_index;
   logic [pf2a_pkg::COLOR_W-1:0]  color_red;
   logic [pf2a_pkg::COLOR_W-1:0]  color_green;
   logic [pf2a_pkg::COLOR_W-1:0]  color_blue;

   modport source (output valid, opcode, pixel_word, palette_index,
                   color_red, color_green, color_blue, input ready);
   modport sink   (input valid, opcode, pixel_word, palette_index,
                   color_red, color_green, color_blue, output ready);
endinterface

interface pf2a_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pf2a_pkg::PIXEL_W-1:0]  argb_pixel;
   logic                          format_error;

   modport source (output valid, argb_pixel, format_error, input ready);
   modport sink   (input valid, argb_pixel, format_error, output ready);
endinterface

>>> rtl/core/pixel_format_to_argb32.sv
// Top level: pixel format converter to opaque 32-bit ARGB, three-stage pipeline.
`timescale 1ns / 1ps
//
//   Channel   Direction  Handshake          Word contents
//   req_bus   in         valid/ready        opcode, pixel_word, palette_index, colors
//   rsp_bus   out        valid/ready        argb_pixel, format_error
//   csr_*     in         write enable only  register index, 32-bit write data
//
// One word enters per cycle while rsp_bus does not hold the pipe; a convert
// word passes through the three register stages (decode and palette read,
// channel unpacking, output register) before it is valid on rsp_bus.
// Palette writes finish at the accept edge and give no response. Reset is
// synchronous and clears the valid bits and the configuration registers; the
// palette is not cleared. Each stage holds its word while the stage after it
// is full and stalled, so a bubble anywhere in the pipe still lets a new word
// in while a finished response waits.
module pixel_format_to_argb32 (
   input  logic                            clock,
   input  logic                            reset,
   pf2a_req_if.sink                        req_bus,
   pf2a_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [pf2a_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pf2a_pkg::CSR_DW-1:0]     csr_wdata
);
   import pf2a_pkg::*;

   // Configuration registers.
   logic [2:0]  pixel_bytes_ff;
   logic [2:0]  visual_class_ff;
   logic [8:0]  pal_entries_ff;
   logic [31:0] red_mask_ff;
   logic [31:0] green_mask_ff;
   logic [31:0] blue_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff  <= BYTES_4;
         visual_class_ff <= 3'd4;
         pal_entries_ff  <= 9'd0;
         red_mask_ff     <= M_FF0000;
         green_mask_ff   <= M_00FF00;
         blue_mask_ff    <= M_0000FF;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_PIXEL_BYTES:  pixel_bytes_ff  <= csr_wdata[2:0];
            CSR_VISUAL_CLASS: visual_class_ff <= csr_wdata[2:0];
            CSR_PAL_ENTRIES:  pal_entries_ff  <= csr_wdata[8:0];
            CSR_RED_MASK:     red_mask_ff     <= csr_wdata;
            CSR_GREEN_MASK:   green_mask_ff   <= csr_wdata;
            CSR_BLUE_MASK:    blue_mask_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Format decode from the configuration. It is evaluated for every word
   // at the first stage, so a register write takes effect on the next word.
   logic    m_rgb888, m_bgr888, m_rgba, m_bgra, m_666, m_565, m_bgr565, m_555;
   fmt_type fmt_in;

   always_comb begin
      m_rgb888 = (red_mask_ff == M_FF0000) && (green_mask_ff == M_00FF00)
                 && (blue_mask_ff == M_0000FF);
      m_bgr888 = (red_mask_ff == M_0000FF) && (green_mask_ff == M_00FF00)
                 && (blue_mask_ff == M_FF0000);
      m_rgba   = (red_mask_ff == M_FF000000) && (green_mask_ff == M_FF0000)
                 && (blue_mask_ff == M_00FF00);
      m_bgra   = (red_mask_ff == M_00FF00) && (green_mask_ff == M_FF0000)
                 && (blue_mask_ff == M_FF000000);
      m_666    = (red_mask_ff == M_R666) && (green_mask_ff == M_G666)
                 && (blue_mask_ff == M_B666);
      m_565    = (red_mask_ff == M_R565) && (green_mask_ff == M_G565)
                 && (blue_mask_ff == M_B565);
      m_bgr565 = (red_mask_ff == M_B565) && (green_mask_ff == M_G565)
                 && (blue_mask_ff == M_R565);
      m_555    = (red_mask_ff == M_R555) && (green_mask_ff == M_G555)
                 && (blue_mask_ff == M_B565);

      fmt_in = FMT_ERROR;
      if (visual_class_ff <= VC_PSEUDOCOLOR) begin
         // Indexed visuals need a byte-wide pixel and a colormap that fits.
         if ((pal_entries_ff != 9'd0) && (pal_entries_ff <= 9'(PALETTE_DEPTH))
             && (pixel_bytes_ff == BYTES_1)) begin
            fmt_in = FMT_PALETTE;
         end
      end else if (visual_class_ff <= VC_DIRECTCOLOR) begin
         case (pixel_bytes_ff)
            BYTES_2: begin
               // The 32-bit mask sets win the match and then do not suit 16 bits.
               if (m_rgb888 || m_bgr888 || m_rgba || m_bgra || m_666) fmt_in = FMT_ERROR;
               else if (m_565)    fmt_in = FMT_RGB565;
               else if (m_bgr565) fmt_in = FMT_BGR565;
               else if (m_555)    fmt_in = FMT_RGBX555;
               else               fmt_in = FMT_ERROR;
            end
            BYTES_3: begin
               if (m_rgb888)      fmt_in = FMT_RGB888;
               else if (m_bgr888) fmt_in = FMT_BGR888;
               else               fmt_in = FMT_ERROR;
            end
            BYTES_4: begin
               if (m_rgb888)      fmt_in = FMT_ARGBX888;
               else if (m_bgr888) fmt_in = FMT_ABGRX888;
               else if (m_rgba)   fmt_in = FMT_RGBA888X;
               else if (m_bgra)   fmt_in = FMT_BGRA888X;
               else if (m_666)    fmt_in = FMT_ARGBX666;
               else               fmt_in = FMT_ERROR;
            end
            default: fmt_in = FMT_ERROR;
         endcase
      end
   end

   // Pipeline flow control: a stage may load when it is empty or when the
   // stage after it is moving.
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in;
   logic ready1, ready2, ready3;
   logic req_take;

   assign ready3        = !v3_ff || rsp_bus.ready;
   assign ready2        = !v2_ff || ready3;
   assign ready1        = !v1_ff || ready2;
   assign req_bus.ready = ready1;
   assign req_take      = req_bus.valid && ready1;
   assign v1_in         = req_take && (op_type'(req_bus.opcode) == OP_CONVERT);

   // Palette store: written by palette-write words, read at accept time so the
   // data is registered alongside the first stage.
   logic [RGB_W-1:0] palette_mem [PALETTE_DEPTH];
   logic             pal_wr_hit, pal_rd_hit;
   logic [RGB_W-1:0] pal1_ff;
   logic             pal_hit1_ff;

   assign pal_wr_hit = ({1'b0, req_bus.palette_index} < 9'(PALETTE_DEPTH));
   assign pal_rd_hit = ({1'b0, req_bus.pixel_word[INDEX_W-1:0]} < 9'(PALETTE_DEPTH));

   always_ff @(posedge clock) begin
      if (req_take && (op_type'(req_bus.opcode) == OP_PAL_WRITE) && pal_wr_hit) begin
         palette_mem[req_bus.palette_index[PAL_AW-1:0]] <=
            {req_bus.color_red[15:8], req_bus.color_green[15:8], req_bus.color_blue[15:8]};
      end
      if (v1_in) begin
         pal1_ff <= palette_mem[req_bus.pixel_word[PAL_AW-1:0]];
      end
   end

   // Stage 1: pixel word, decoded format and palette hit.
   logic [PIXEL_W-1:0] pix1_ff;
   fmt_type            fmt1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= v1_in;
      end
      if (v1_in) begin
         pix1_ff     <= req_bus.pixel_word;
         fmt1_ff     <= fmt_in;
         pal_hit1_ff <= pal_rd_hit;
      end
   end

   // Stage 2: unpack and widen the color channels.
   logic [RGB_W-1:0] rgb2_in, rgb2_ff;
   logic             err2_in, err2_ff;
   logic [4:0]       c5a, c5b, c5c;
   logic [5:0]       c6a, c6b, c6c;

   always_comb begin
      c5a     = pix1_ff[15:11];
      c5b     = pix1_ff[14:10];
      c5c     = pix1_ff[9:5];
      c6a     = pix1_ff[10:5];
      c6b     = pix1_ff[17:12];
      c6c     = pix1_ff[11:6];
      err2_in = 1'b0;
      case (fmt1_ff)
         FMT_PALETTE:  rgb2_in = pal_hit1_ff ? pal1_ff : '0;
         FMT_RGB565:   rgb2_in = {c5a, c5a[4:2], c6a, c6a[5:4],
                                  pix1_ff[4:0], pix1_ff[4:2]};
         FMT_BGR565:   rgb2_in = {pix1_ff[4:0], pix1_ff[4:2], c6a, c6a[5:4],
                                  c5a, c5a[4:2]};
         FMT_RGBX555:  rgb2_in = {c5b, c5b[4:2], c5c, c5c[4:2],
                                  pix1_ff[4:0], pix1_ff[4:2]};
         FMT_RGB888,
         FMT_ARGBX888: rgb2_in = pix1_ff[23:0];
         FMT_BGR888,
         FMT_ABGRX888: rgb2_in = {pix1_ff[7:0], pix1_ff[15:8], pix1_ff[23:16]};
         FMT_RGBA888X: rgb2_in = pix1_ff[31:8];
         FMT_BGRA888X: rgb2_in = {pix1_ff[15:8], pix1_ff[23:16], pix1_ff[31:24]};
         FMT_ARGBX666: rgb2_in = {c6b, c6b[5:4], c6c, c6c[5:4],
                                  pix1_ff[5:0], pix1_ff[5:4]};
         default: begin
            rgb2_in = '0;
            err2_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
      end
      if (ready2 && v1_ff) begin
         rgb2_ff <= rgb2_in;
         err2_ff <= err2_in;
      end
   end

   // Stage 3: output register, opaque alpha or an all-zero error word.
   logic [PIXEL_W-1:0] argb3_in, argb3_ff;
   logic               err3_ff;

   assign argb3_in = err2_ff ? '0 : {8'hff, rgb2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ready3) begin
         v3_ff <= v2_ff;
      end
      if (ready3 && v2_ff) begin
         argb3_ff <= argb3_in;
         err3_ff  <= err2_ff;
      end
   end

   assign rsp_bus.valid        = v3_ff;
   assign rsp_bus.argb_pixel   = argb3_ff;
   assign rsp_bus.format_error = err3_ff;

`include "pixel_format_to_argb32_assert.svh"

   `PF2A_ASSERT_NEXT(a_convert_enters, clock, reset, v1_in, v1_ff, "accepted convert word lost at stage 1")
   `PF2A_ASSERT_NEXT(a_write_no_rsp, clock, reset, req_take && !v1_in, !v1_ff, "palette write entered the pipe")
   `PF2A_ASSERT_IMPLY(a_opaque, clock, reset, v3_ff && !err3_ff, argb3_ff[31:24] == 8'hff, "good pixel not opaque")
   `PF2A_ASSERT_IMPLY(a_err_zero, clock, reset, v3_ff && err3_ff, argb3_ff == '0, "error word not zero")

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the pixel format converter to opaque 32-bit ARGB.
`timescale 1ns / 1ps
module tb_top;
   import pf2a_pkg::*;

   // Timing of the run. The pipe is three stages deep, so waiting SETTLE_CYCLES
   // after the last response is enough to be sure that nothing is in flight.
   localparam int          HALF_PERIOD  = 6;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          HOLD_CYCLES  = 200;
   localparam int          RUN_LIMIT_NS = 4_000_000;
   localparam int unsigned LOAD_PCT     = 15;

   // Visual classes and pixel sizes that the package does not name.
   localparam logic [2:0] VC_STATIC_GRAY = 3'd0;
   localparam logic [2:0] VC_GRAY_SCALE  = 3'd1;
   localparam logic [2:0] VC_STATIC_COLOR = 3'd2;
   localparam logic [2:0] VC_TRUE_COLOR  = 3'd4;
   localparam logic [2:0] VC_UNUSED      = 3'd7;
   localparam logic [2:0] BYTES_NONE     = 3'd0;
   localparam logic [2:0] BYTES_FIELD_MAX = 3'd7;
   localparam int         FMT_COUNT      = 12;

   typedef struct packed {
      op_type               op;
      logic [PIXEL_W-1:0]   pixel;
      logic [INDEX_W-1:0]   index;
      logic [COLOR_W-1:0]   red;
      logic [COLOR_W-1:0]   green;
      logic [COLOR_W-1:0]   blue;
   } pixel_req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] argb;
      logic               err;
   } pixel_result_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PIXEL_BYTES;
   logic [CSR_DW-1:0]    csr_wdata = '0;

   pf2a_req_if req_if ();
   pf2a_rsp_if rsp_if ();

   pixel_format_to_argb32 dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Our own copy of the configuration registers and of the palette. The
   // loaded bits track which palette entries hold a defined color, so that
   // the stimulus never reads an entry that was never written.
   logic [2:0]         cfg_bytes;
   logic [2:0]         cfg_class;
   logic [8:0]         cfg_entries;
   logic [31:0]        cfg_red_mask;
   logic [31:0]        cfg_green_mask;
   logic [31:0]        cfg_blue_mask;
   logic [RGB_W-1:0]   palette_rgb [PALETTE_DEPTH];
   bit                 palette_loaded [PALETTE_DEPTH];
   logic [INDEX_W-1:0] last_loaded_index = '0;

   // Converted pixels that the block still owes us, oldest first.
   pixel_result_type expected_pixels [$];

   // Idle behavior of both sides, in percent of cycles.
   int unsigned gap_pct   = 0;
   int unsigned stall_pct = 0;
   bit          hold_go   = 1'b0;

   // Bookkeeping for the verdict and the closing summary.
   int n_pixels     = 0;
   int n_loads      = 0;
   int n_err_pixels = 0;
   int n_checked    = 0;
   int bad_results  = 0;
   bit fmt_seen [FMT_COUNT];

   function automatic bit masks_are(input logic [31:0] r, input logic [31:0] g,
                                    input logic [31:0] b);
      return cfg_red_mask == r && cfg_green_mask == g && cfg_blue_mask == b;
   endfunction

   // Works out which conversion the current settings select. Indexed classes
   // need one-byte pixels and a colormap of 1 to PALETTE_DEPTH entries. The
   // true and direct color classes go by masks; 24-bit pixels accept only the
   // two byte-wide orders, and any other match must suit the pixel size.
   function automatic fmt_type decode_format();
      fmt_type by_masks;
      if (cfg_class <= VC_PSEUDOCOLOR) begin
         if (cfg_entries == '0 || int'(cfg_entries) > PALETTE_DEPTH || cfg_bytes != BYTES_1)
            return FMT_ERROR;
         return FMT_PALETTE;
      end
      if (cfg_class > VC_DIRECTCOLOR)
         return FMT_ERROR;
      if (cfg_bytes == BYTES_3) begin
         if (masks_are(M_FF0000, M_00FF00, M_0000FF)) return FMT_RGB888;
         if (masks_are(M_0000FF, M_00FF00, M_FF0000)) return FMT_BGR888;
         return FMT_ERROR;
      end
      by_masks = FMT_ERROR;
      if (masks_are(M_FF0000, M_00FF00, M_0000FF))        by_masks = FMT_ARGBX888;
      else if (masks_are(M_0000FF, M_00FF00, M_FF0000))   by_masks = FMT_ABGRX888;
      else if (masks_are(M_FF000000, M_FF0000, M_00FF00)) by_masks = FMT_RGBA888X;
      else if (masks_are(M_00FF00, M_FF0000, M_FF000000)) by_masks = FMT_BGRA888X;
      else if (masks_are(M_R666, M_G666, M_B666))         by_masks = FMT_ARGBX666;
      else if (masks_are(M_R565, M_G565, M_B565))         by_masks = FMT_RGB565;
      else if (masks_are(M_B565, M_G565, M_R565))         by_masks = FMT_BGR565;
      else if (masks_are(M_R555, M_G555, M_B565))         by_masks = FMT_RGBX555;
      if (cfg_bytes == BYTES_2 && by_masks inside {FMT_RGB565, FMT_BGR565, FMT_RGBX555})
         return by_masks;
      if (cfg_bytes == BYTES_4 && by_masks inside {FMT_ARGBX888, FMT_ABGRX888, FMT_RGBA888X,
                                                   FMT_BGRA888X, FMT_ARGBX666})
         return by_masks;
      return FMT_ERROR;
   endfunction

   // Expected response for one pixel. Narrow channels are widened by
   // repeating their top bits in the low bits of the byte.
   function automatic pixel_result_type predict_argb(input fmt_type f, input logic [31:0] p);
      pixel_result_type r;
      logic [23:0]      rgb;
      r.err = 1'b0;
      case (f)
         FMT_PALETTE:  rgb = palette_rgb[p[7:0]];
         FMT_RGB565:   rgb = {p[15:11], p[15:13], p[10:5], p[10:9], p[4:0], p[4:2]};
         FMT_BGR565:   rgb = {p[4:0], p[4:2], p[10:5], p[10:9], p[15:11], p[15:13]};
         FMT_RGBX555:  rgb = {p[14:10], p[14:12], p[9:5], p[9:7], p[4:0], p[4:2]};
         FMT_RGB888:   rgb = p[23:0];
         FMT_BGR888:   rgb = {p[7:0], p[15:8], p[23:16]};
         FMT_ARGBX888: rgb = p[23:0];
         FMT_ABGRX888: rgb = {p[7:0], p[15:8], p[23:16]};
         FMT_RGBA888X: rgb = p[31:8];
         FMT_BGRA888X: rgb = {p[15:8], p[23:16], p[31:24]};
         FMT_ARGBX666: rgb = {p[17:12], p[17:16], p[11:6], p[11:10], p[5:0], p[5:4]};
         default: begin
            r.argb = '0;
            r.err  = 1'b1;
            return r;
         end
      endcase
      r.argb = {8'hff, rgb};
      return r;
   endfunction

   function automatic void packing_masks(input fmt_type f, output logic [2:0] nbytes,
                                         output logic [31:0] rm, output logic [31:0] gm,
                                         output logic [31:0] bm);
      case (f)
         FMT_RGB565:   begin nbytes = BYTES_2; rm = M_R565;     gm = M_G565;   bm = M_B565;     end
         FMT_BGR565:   begin nbytes = BYTES_2; rm = M_B565;     gm = M_G565;   bm = M_R565;     end
         FMT_RGBX555:  begin nbytes = BYTES_2; rm = M_R555;     gm = M_G555;   bm = M_B565;     end
         FMT_RGB888:   begin nbytes = BYTES_3; rm = M_FF0000;   gm = M_00FF00; bm = M_0000FF;   end
         FMT_BGR888:   begin nbytes = BYTES_3; rm = M_0000FF;   gm = M_00FF00; bm = M_FF0000;   end
         FMT_ABGRX888: begin nbytes = BYTES_4; rm = M_0000FF;   gm = M_00FF00; bm = M_FF0000;   end
         FMT_RGBA888X: begin nbytes = BYTES_4; rm = M_FF000000; gm = M_FF0000; bm = M_00FF00;   end
         FMT_BGRA888X: begin nbytes = BYTES_4; rm = M_00FF00;   gm = M_FF0000; bm = M_FF000000; end
         FMT_ARGBX666: begin nbytes = BYTES_4; rm = M_R666;     gm = M_G666;   bm = M_B666;     end
         default:      begin nbytes = BYTES_4; rm = M_FF0000;   gm = M_00FF00; bm = M_0000FF;   end
      endcase
   endfunction

   function automatic pixel_req_type make_pixel(input logic [31:0] p);
      pixel_req_type w;
      w.op    = OP_CONVERT;
      w.pixel = p;
      w.index = INDEX_W'($urandom);
      w.red   = COLOR_W'($urandom);
      w.green = COLOR_W'($urandom);
      w.blue  = COLOR_W'($urandom);
      return w;
   endfunction

   function automatic pixel_req_type make_load(input logic [7:0] idx, input logic [15:0] r,
                                               input logic [15:0] g, input logic [15:0] b);
      pixel_req_type w;
      w.op    = OP_PAL_WRITE;
      w.pixel = $urandom;
      w.index = idx;
      w.red   = r;
      w.green = g;
      w.blue  = b;
      return w;
   endfunction

   function automatic logic [31:0] random_pixel();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Masks for the unsupported settings: mostly the values that real
   // packings use, so that wrong pairings of size and masks come up often.
   function automatic logic [31:0] random_mask();
      case ($urandom_range(0, 9))
         0:       return M_FF0000;
         1:       return M_00FF00;
         2:       return M_0000FF;
         3:       return M_FF000000;
         4:       return M_R565;
         5:       return M_G565;
         6:       return '0;
         7:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Registers are written one at a time while no word is in flight.
   task automatic write_reg(input csr_idx_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_PIXEL_BYTES:  cfg_bytes      = data[2:0];
         CSR_VISUAL_CLASS: cfg_class      = data[2:0];
         CSR_PAL_ENTRIES:  cfg_entries    = data[8:0];
         CSR_RED_MASK:     cfg_red_mask   = data;
         CSR_GREEN_MASK:   cfg_green_mask = data;
         CSR_BLUE_MASK:    cfg_blue_mask  = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_setting(input logic [2:0] nbytes, input logic [2:0] vclass,
                                input logic [8:0] entries, input logic [31:0] rm,
                                input logic [31:0] gm, input logic [31:0] bm);
      write_reg(CSR_PIXEL_BYTES, 32'(nbytes));
      write_reg(CSR_VISUAL_CLASS, 32'(vclass));
      write_reg(CSR_PAL_ENTRIES, 32'(entries));
      write_reg(CSR_RED_MASK, rm);
      write_reg(CSR_GREEN_MASK, gm);
      write_reg(CSR_BLUE_MASK, bm);
   endtask

   task automatic set_packing(input fmt_type f, input logic [2:0] vclass);
      logic [2:0]  nbytes;
      logic [31:0] rm, gm, bm;
      packing_masks(f, nbytes, rm, gm, bm);
      write_setting(nbytes, vclass, 9'($urandom), rm, gm, bm);
   endtask

   // Offers one word on the request channel. Valid stays high after the
   // accept edge, so the next word follows without a bubble unless the
   // sender decides to idle. The expectation is formed at the accept edge.
   task automatic send_word(input pixel_req_type w);
      fmt_type f;
      @(negedge clock);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.opcode        <= w.op;
      req_if.pixel_word    <= w.pixel;
      req_if.palette_index <= w.index;
      req_if.color_red     <= w.red;
      req_if.color_green   <= w.green;
      req_if.color_blue    <= w.blue;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (w.op == OP_PAL_WRITE) begin
         palette_rgb[w.index]    = {w.red[15:8], w.green[15:8], w.blue[15:8]};
         palette_loaded[w.index] = 1'b1;
         last_loaded_index       = w.index;
         n_loads++;
      end else begin
         f = decode_format();
         expected_pixels.push_back(predict_argb(f, w.pixel));
         fmt_seen[int'(f)] = 1'b1;
         n_pixels++;
         if (f == FMT_ERROR) n_err_pixels++;
      end
   endtask

   // Under an indexed class an entry that was never loaded gets a color
   // first, so the palette read is always defined.
   task automatic send_pixel(input logic [31:0] p);
      if (cfg_class <= VC_PSEUDOCOLOR && !palette_loaded[p[7:0]])
         send_word(make_load(p[7:0], COLOR_W'($urandom), COLOR_W'($urandom),
                             COLOR_W'($urandom)));
      send_word(make_pixel(p));
   endtask

   // Waits until every converted pixel has come back, then SETTLE_CYCLES more
   // so that the block is idle before the next register write.
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic try_error_setting(input logic [2:0] nbytes, input logic [2:0] vclass,
                                    input logic [8:0] entries, input logic [31:0] rm,
                                    input logic [31:0] gm, input logic [31:0] bm);
      drain();
      write_setting(nbytes, vclass, entries, rm, gm, bm);
      send_pixel($urandom);
   endtask

   // Picks a new configuration. Most settings are supported packings with
   // random content, some use the palette, and the rest are arbitrary values
   // in every register, which mostly end up as format errors.
   task automatic apply_random_setting(output bit indexed);
      int          pick;
      logic [2:0]  nbytes;
      logic [8:0]  entries;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         set_packing(fmt_type'(int'(FMT_RGB565) + $urandom_range(0, 9)),
                     $urandom_range(0, 1) ? VC_DIRECTCOLOR : VC_TRUE_COLOR);
         indexed = 1'b0;
      end else if (pick < 8) begin
         nbytes = ($urandom_range(0, 9) == 0) ? 3'($urandom) : BYTES_1;
         case ($urandom_range(0, 3))
            0:       entries = 9'd1;
            1:       entries = 9'(PALETTE_DEPTH);
            default: entries = 9'($urandom_range(1, PALETTE_DEPTH));
         endcase
         write_setting(nbytes, 3'($urandom_range(0, 3)), entries, $urandom, $urandom,
                       $urandom);
         indexed = 1'b1;
      end else begin
         write_setting(3'($urandom), 3'($urandom), 9'($urandom), random_mask(),
                       random_mask(), random_mask());
         indexed = (cfg_class <= VC_PSEUDOCOLOR);
      end
   endtask

   task automatic send_random_item(input bit indexed);
      logic [31:0] p;
      if ($urandom_range(0, 99) < LOAD_PCT) begin
         send_word(make_load(INDEX_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                             COLOR_W'($urandom)));
      end else begin
         p = random_pixel();
         // Under the palette, half the reads go to the entry loaded last.
         if (indexed && $urandom_range(0, 1) == 1) p[7:0] = last_loaded_index;
         send_pixel(p);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Out of reset the block expects 32-bit pixels with the red, green and
   // blue bytes in the low three bytes.
   task automatic test_default_format();
      send_pixel(32'hffff_ffff);
      send_pixel(32'h0000_0000);
   endtask

   // One pixel through each of the ten direct packings, alternating between
   // the true color and direct color classes.
   task automatic test_direct_packings();
      for (int n = 0; n < 10; n++) begin
         drain();
         set_packing(fmt_type'(int'(FMT_RGB565) + n), n[0] ? VC_DIRECTCOLOR : VC_TRUE_COLOR);
         send_pixel(n[0] ? 32'hffff_ffff : 32'h9c3a_5e61);
      end
   endtask

   // Palette loads at both ends of the index range, reads that ignore the
   // upper pixel bytes, and a read beyond the colormap size, which still
   // returns the stored color.
   task automatic test_palette_lookup();
      drain();
      write_setting(BYTES_1, VC_PSEUDOCOLOR, 9'(PALETTE_DEPTH), '0, '0, '0);
      send_word(make_load(8'h00, 16'hffff, 16'h0000, 16'hffff));
      send_word(make_load(8'hff, 16'h00ff, 16'hff00, 16'h8000));
      send_pixel(32'hffff_ff00);
      send_pixel(32'h0000_00ff);
      drain();
      write_reg(CSR_VISUAL_CLASS, 32'(VC_STATIC_GRAY));
      write_reg(CSR_PAL_ENTRIES, 32'd1);
      send_pixel(32'h1234_56ff);
   endtask

   // Settings that select no format must answer with the error flag.
   task automatic test_unsupported_formats();
      try_error_setting(BYTES_4, VC_UNUSED, 9'd0, M_FF0000, M_00FF00, M_0000FF);
      try_error_setting(BYTES_NONE, VC_TRUE_COLOR, 9'd0, M_FF0000, M_00FF00, M_0000FF);
      try_error_setting(BYTES_FIELD_MAX, VC_DIRECTCOLOR, 9'd0, M_FF0000, M_00FF00, M_0000FF);
      try_error_setting(BYTES_1, VC_TRUE_COLOR, 9'd16, M_FF0000, M_00FF00, M_0000FF);
      try_error_setting(BYTES_1, VC_GRAY_SCALE, 9'd0, '0, '0, '0);
      try_error_setting(BYTES_1, VC_STATIC_COLOR, 9'h1ff, '0, '0, '0);
      try_error_setting(BYTES_2, VC_PSEUDOCOLOR, 9'd16, M_R565, M_G565, M_B565);
      try_error_setting(BYTES_4, VC_TRUE_COLOR, 9'd0, '0, '1, '0);
      try_error_setting(BYTES_4, VC_TRUE_COLOR, 9'd0, M_R565, M_G565, M_B565);
      try_error_setting(BYTES_3, VC_DIRECTCOLOR, 9'd0, M_FF000000, M_FF0000, M_00FF00);
   endtask

   // Random words under a sequence of random settings, with the given idle
   // rates on both sides.
   task automatic test_random_traffic(input int unsigned src_gap, input int unsigned dst_stall,
                                      input int n_items);
      int sent;
      bit indexed;
      gap_pct   = src_gap;
      stall_pct = dst_stall;
      sent      = 0;
      while (sent < n_items) begin
         drain();
         apply_random_setting(indexed);
         repeat ($urandom_range(15, 60)) begin
            send_random_item(indexed);
            sent++;
         end
      end
   endtask

   // The response side holds off for a long stretch while words keep coming,
   // so the pipe fills and the request side must stall.
   task automatic test_output_backpressure();
      drain();
      gap_pct   = 0;
      stall_pct = 0;
      set_packing(FMT_ARGBX666, VC_TRUE_COLOR);
      hold_go = 1'b1;
      repeat (40) send_pixel(random_pixel());
   endtask

   // ---------------------------------------------------------------------
   // Response side: ready is driven at the falling edge, words are taken at
   // the rising edge. A hold request forces ready low for HOLD_CYCLES.
   // ---------------------------------------------------------------------
   initial begin : drive_rsp_ready
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Every accepted response is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      pixel_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_pixels.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
               $display("%0t: unexpected response argb_pixel %h format_error %b", $time,
                        rsp_if.argb_pixel, rsp_if.format_error);
         end else begin
            want = expected_pixels.pop_front();
            n_checked++;
            if (rsp_if.argb_pixel !== want.argb || rsp_if.format_error !== want.err) begin
               bad_results++;
               if (bad_results <= 10)
                  $display("%0t: mismatch argb_pixel exp %h got %h, format_error exp %b got %b",
                           $time, want.argb, rsp_if.argb_pixel, want.err,
                           rsp_if.format_error);
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin : run_limit
      #RUN_LIMIT_NS;
      $display("Run limit reached with %0d responses outstanding", expected_pixels.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : run_tests
      int n_formats;
      req_if.valid         = 1'b0;
      req_if.opcode        = OP_CONVERT;
      req_if.pixel_word    = '0;
      req_if.palette_index = '0;
      req_if.color_red     = '0;
      req_if.color_green   = '0;
      req_if.color_blue    = '0;

      // Register values after reset; no palette entry holds a color yet.
      cfg_bytes      = BYTES_4;
      cfg_class      = VC_TRUE_COLOR;
      cfg_entries    = '0;
      cfg_red_mask   = M_FF0000;
      cfg_green_mask = M_00FF00;
      cfg_blue_mask  = M_0000FF;
      foreach (palette_loaded[k]) palette_loaded[k] = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gap_pct   = 25;
      stall_pct = 52;
      test_default_format();
      test_direct_packings();
      test_palette_lookup();
      test_unsupported_formats();
      test_random_traffic(25, 52, 630);
      test_random_traffic(52, 25, 630);
      test_random_traffic(0, 0, 630);
      test_output_backpressure();
      drain();

      n_formats = 0;
      for (int k = 0; k < FMT_COUNT; k++) if (fmt_seen[k]) n_formats++;
      $display("Checked %0d of %0d converted pixels (%0d with format errors), %0d palette loads.",
               n_checked, n_pixels, n_err_pixels, n_loads);
      $display("Reached %0d of %0d decode outcomes, including palette lookup and error.",
               n_formats, FMT_COUNT);

      if (bad_results == 0 && expected_pixels.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
